### rtl/spq_pkg.sv
// Shared types, codes and constants of the sorted priority queue.
package spq_pkg;

    // Default number of queue slots.
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Operation codes; the unused fourth code behaves as a query.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Error codes of a result.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // Front values reported while the queue is empty.
    localparam logic signed [15:0] EMPTY_ID  = -16'sd1;
    localparam logic signed [15:0] EMPTY_KEY = 16'sd10000;

    // Input transaction.
    typedef struct packed {
        logic [1:0]         opcode;
        logic [14:0]        entry_id;
        logic signed [15:0] entry_key;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic signed [15:0] front_id;
        logic signed [15:0] front_key;
        logic               is_empty;
        logic [4:0]         entry_count;
        logic [1:0]         error_code;
    } t_out;

    // Contents of one slot of the chain.
    typedef struct packed {
        logic               valid;
        logic [14:0]        id;
        logic signed [15:0] key;
    } t_slot;

    // Control broadcast to every cell in a cycle.
    typedef struct packed {
        logic  push;
        logic  pop;
        t_slot entry;
    } t_cell_ctrl;

    localparam t_slot SLOT_NONE = '0;

endpackage

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_slot      i_prev_slot,
    input  logic       i_prev_keep,
    input  t_slot      i_next_slot,
    output t_slot      o_slot,
    output logic       o_keep,
    output t_slot      o_next_value
);

    t_slot r_slot;
    t_slot n_slot;

    // This entry stays ahead of a new one when its key is less or equal.
    assign o_keep = r_slot.valid && (r_slot.key <= i_ctrl.entry.key);

    // Push shifts back behind the insertion point; pop shifts forward.
    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.push) begin
            if (o_keep) begin
                n_slot = r_slot;
            end else if (i_prev_keep) begin
                n_slot = i_ctrl.entry;
            end else begin
                n_slot = i_prev_slot;
            end
        end else if (i_ctrl.pop) begin
            n_slot = i_next_slot;
        end
    end

    // Only the valid bit needs a reset.
    always_ff @(posedge i_clk) begin
        r_slot.id  <= n_slot.id;
        r_slot.key <= n_slot.key;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

    assign o_slot       = r_slot;
    assign o_next_value = n_slot;

endmodule

### rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of slot cells and a result register.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data  (t_in)
//   out      output     o_out_valid / i_out_stall o_out_data (t_out)
//
// Every cell compares and shifts in the same cycle, so a transaction is applied
// in the cycle it is accepted and its result sits in the output register in the
// next cycle. One transaction is taken per cycle while the output register is
// empty or being read. Reset clears the slot valid bits, the count and the output
// valid at once; there is no clearing pass. A stalled output stalls the input.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

    logic [CountWidth-1:0] r_count;
    logic [CountWidth-1:0] n_count;
    logic                  r_out_valid;
    t_out                  r_out_data;
    t_out                  n_out_data;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_is_push;
    logic                   w_is_pop;
    logic [1:0]             w_error;
    t_cell_ctrl             w_ctrl;
    t_slot                  w_slot [QUEUE_DEPTH];
    t_slot                  w_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [CountWidth+4:0]  w_count_wide;

    // Input handshake.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Decode the operation and its refusal cases.
    assign w_full    = (r_count == CountWidth'(QUEUE_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_is_push = (i_in_data.opcode == OP_PUSH);
    assign w_is_pop  = (i_in_data.opcode == OP_POP);

    always_comb begin
        w_error = ERR_NONE;
        if (w_is_push && w_full) begin
            w_error = ERR_FULL;
        end else if (w_is_pop && w_empty) begin
            w_error = ERR_EMPTY;
        end
    end

    // Control broadcast to the chain.
    always_comb begin
        w_ctrl.push        = w_accept && w_is_push && !w_full;
        w_ctrl.pop         = w_accept && w_is_pop && !w_empty;
        w_ctrl.entry.valid = 1'b1;
        w_ctrl.entry.id    = i_in_data.entry_id;
        w_ctrl.entry.key   = i_in_data.entry_key;
    end

    // Chain of cells; slot zero always holds the smallest entry.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot prev_slot;
        t_slot next_slot;
        logic  prev_keep;

        if (g == 0) begin : g_first
            assign prev_slot = SLOT_NONE;
            assign prev_keep = 1'b1;
        end else begin : g_inner
            assign prev_slot = w_slot[g-1];
            assign prev_keep = w_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign next_slot = SLOT_NONE;
        end else begin : g_body
            assign next_slot = w_slot[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_slot  (prev_slot),
            .i_prev_keep  (prev_keep),
            .i_next_slot  (next_slot),
            .o_slot       (w_slot[g]),
            .o_keep       (w_keep[g]),
            .o_next_value (w_next[g])
        );

        assign w_valid[g] = w_slot[g].valid;
    end

    // Entry count after the operation.
    always_comb begin
        n_count = r_count;
        if (w_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_count_wide = {5'b0, n_count};

    // Result from the next contents of slot zero.
    always_comb begin
        n_out_data.is_empty    = !w_next[0].valid;
        n_out_data.front_id    = w_next[0].valid ? {1'b0, w_next[0].id} : EMPTY_ID;
        n_out_data.front_key   = w_next[0].valid ? w_next[0].key : EMPTY_KEY;
        n_out_data.entry_count = w_count_wide[4:0];
        n_out_data.error_code  = w_error;
    end

    // Count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    // The count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountWidth'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // The valid slots match the count.
    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("valid slots disagree with entry count");

    // A successful push grows the queue by one entry.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not add an entry");

    // Slot zero never holds a larger key than slot one.
    if (QUEUE_DEPTH > 1) begin : g_order_check
        a_front_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_slot[1].valid |-> (w_slot[0].valid && w_slot[0].key <= w_slot[1].key))
            else $error("front entry out of order");
    end
`endif

endmodule
